// ===== rtl/dct_pkg.sv =====
`default_nettype none

package dct_pkg;

  typedef struct packed {
    logic [7:0] base_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       amino_valid;
    logic [7:0] amino_char;
    logic       seq_end;
  } out_item_t;

  // Result of one step of the codon unit, plus a status flag for checking.
  typedef struct packed {
    logic      emit;
    logic      at_start;
    out_item_t item;
  } step_res_t;

  typedef enum logic [2:0] {
    PH_B1 = 3'b001,
    PH_B2 = 3'b010,
    PH_B3 = 3'b100
  } phase_e;

  // RNA base codes
  localparam logic [2:0] RNA_U   = 3'd0;
  localparam logic [2:0] RNA_C   = 3'd1;
  localparam logic [2:0] RNA_A   = 3'd2;
  localparam logic [2:0] RNA_G   = 3'd3;
  localparam logic [2:0] RNA_BAD = 3'd4;

  localparam logic [7:0] CHAR_UNKNOWN = "-";
  localparam logic [7:0] CHAR_NONE    = 8'h00;

  // Codon index 16*b1 + 4*b2 + b3 of the stop codons
  localparam logic [5:0] IDX_UAA = 6'd10;
  localparam logic [5:0] IDX_UAG = 6'd11;
  localparam logic [5:0] IDX_UGA = 6'd14;

  localparam logic [7:0] AMINO_TAB [64] = '{
    "F","F","L","L", "S","S","S","S", "Y","Y","-","-", "C","C","-","W",
    "L","L","L","L", "P","P","P","P", "H","H","Q","Q", "R","R","R","R",
    "I","I","I","M", "T","T","T","T", "N","N","K","K", "S","S","R","R",
    "V","V","V","V", "A","A","A","A", "D","D","E","E", "G","G","G","G"
  };

  // Template strand base to RNA code of its complement
  function automatic logic [2:0] rna_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      "A":     code = RNA_U;
      "G":     code = RNA_C;
      "T":     code = RNA_A;
      "C":     code = RNA_G;
      default: code = RNA_BAD;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dna_codon_translator_top.sv =====
`default_nettype none
// Input register, then codon table lookup, then result register.
// Throughput: one base per cycle unless the output stalls.
// A stalled output holds the result register and backs up into the input register.
// Reset (rst_ni low, asynchronous): pipeline empty, codon phase at first base,
// held bases cleared.

module dna_codon_translator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dct_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dct_pkg::out_item_t      out_item_o
);
  import dct_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  step_res_t res;
  logic      out_load_ok;
  logic      s1_drain;
  logic      in_take;

  assign out_load_ok = !out_valid_q || !out_stall_i;
  assign s1_drain    = s1_valid_q && (!res.emit || out_load_ok);
  assign in_stall_o  = s1_valid_q && !s1_drain;
  assign in_take     = in_valid_i && !in_stall_o;

  dct_codon_unit u_codon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_drain),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take || s1_drain) begin
        s1_valid_q <= in_take;
      end
      if (out_load_ok) begin
        out_valid_q <= s1_drain && res.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
    if (out_load_ok && s1_drain && res.emit) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // after the final base the codon unit starts afresh
  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_drain && s1_item_q.is_last |=> res.at_start)
    else $error("codon phase not cleared after final base");

  // a final base always leaves a result behind
  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_drain && s1_item_q.is_last |=> out_valid_q && out_item_q.seq_end)
    else $error("final base gave no end-of-sequence transaction");

  // no residue means an empty character, a residue never is empty
  a_char_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.amino_valid == (out_item_q.amino_char != CHAR_NONE)))
    else $error("amino character inconsistent with amino_valid");

  // the input register only stalls when the result register is blocked
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

// ===== rtl/dct_codon_unit.sv =====
`default_nettype none

module dct_codon_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire dct_pkg::in_item_t  item_i,
  output dct_pkg::step_res_t      res_o
);
  import dct_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] first_q, first_d;
  logic [2:0] second_q, second_d;
  logic [2:0] code;
  logic [5:0] idx;
  logic       bad;
  logic       stop;

  assign code = rna_code(item_i.base_char);
  assign idx  = {first_q[1:0], second_q[1:0], code[1:0]};
  assign bad  = first_q[2] | second_q[2] | code[2];
  assign stop = (idx == IDX_UAA) || (idx == IDX_UAG) || (idx == IDX_UGA);

  always_comb begin
    phase_d       = phase_q;
    first_d       = first_q;
    second_d      = second_q;
    res_o.emit    = 1'b0;
    res_o.at_start = (phase_q == PH_B1);
    res_o.item    = '{amino_valid: 1'b0, amino_char: CHAR_NONE, seq_end: item_i.is_last};
    case (phase_q)
      PH_B1: begin
        first_d = code;
        phase_d = PH_B2;
      end
      PH_B2: begin
        second_d = code;
        phase_d  = PH_B3;
      end
      default: begin
        // codon complete
        res_o.emit = 1'b1;
        if (bad) begin
          res_o.item.amino_valid = 1'b1;
          res_o.item.amino_char  = CHAR_UNKNOWN;
        end else if (!stop) begin
          res_o.item.amino_valid = 1'b1;
          res_o.item.amino_char  = AMINO_TAB[idx];
        end
        phase_d  = PH_B1;
        first_d  = RNA_U;
        second_d = RNA_U;
      end
    endcase
    if (item_i.is_last) begin
      // partial codon dropped, but the end still shows as a transaction
      res_o.emit = 1'b1;
      phase_d    = PH_B1;
      first_d    = RNA_U;
      second_d   = RNA_U;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B1;
      first_q  <= RNA_U;
      second_q <= RNA_U;
    end else if (step_i) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire
